// File: rtl/core/fpfa_pkg.sv
// Shared types and codes for the fixed-partition first-fit allocator.
package fpfa_pkg;

  // Request kinds
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ALLOC   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;

  localparam int SIZE_W = 16;
  localparam int ADDR_W = 20;
  localparam int INDEX_W = 5;

  // One partition table entry
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              busy;
  } entry_t;

endpackage

// File: rtl/core/fpfa_table.sv
// Partition table: one synchronous RAM with per-entry valid bits for reset.
module fpfa_table #(
  parameter int PARTITIONS = 16,
  parameter int IDX_W      = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  fpfa_pkg::entry_t    wr_data,
  input  logic [IDX_W-1:0]    rd_idx,
  output fpfa_pkg::entry_t    rd_data
);
  import fpfa_pkg::*;

  entry_t                 mem [PARTITIONS];
  logic [PARTITIONS-1:0]  valid_r;
  entry_t                 rd_q_r;
  logic                   rd_vld_r;

  // valid bits: an entry never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q_r   <= mem[rd_idx];
    rd_vld_r <= valid_r[rd_idx];
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: rtl/core/fixed_partition_first_fit_allocator.sv
// Top level of the fixed-partition first-fit allocator.
//
// Keeps a table of up to PARTITIONS memory partitions (size, start address,
// busy mark) in one single-port-read synchronous RAM. A load request appends
// the next partition at the running end address; an allocate request scans
// entries from index one up to min(partition_count, PARTITIONS), one entry
// per cycle, and marks the first free one that is large enough as busy; a
// release request clears the busy mark of the given one-based index. Every
// request returns exactly one result. A load or a rejected request passes
// from idle straight to the push state; a release first reads its entry in
// the release state; an allocate stays in the scan state until a hit or the
// scan limit, none if it is 0; the table's one read port sets the scan rate.
// Requests are handled one at a time; a new request is taken while the
// previous result still waits in the output register. No clearing pass is
// needed after reset: per-entry valid bits make unwritten entries read as
// empty and free. The user must write partition_count through the cfg port
// only while idle; the block itself does not enforce this.
module fixed_partition_first_fit_allocator #(
  parameter int PARTITIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [4:0]                    cfg_partition_count,
  // requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [fpfa_pkg::SIZE_W-1:0]   in_amount,
  input  logic [fpfa_pkg::INDEX_W-1:0]  in_release_index,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [fpfa_pkg::INDEX_W-1:0]  out_part_index,
  output logic [fpfa_pkg::ADDR_W-1:0]   out_part_address,
  output logic [fpfa_pkg::SIZE_W-1:0]   out_part_size
);
  import fpfa_pkg::*;

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W = $clog2(PARTITIONS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REL,
    ST_PUSH
  } state_t;

  state_t              state_r, state_nxt;
  logic [4:0]          count_r, count_nxt;
  logic [CNT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [ADDR_W-1:0]   run_end_r, run_end_nxt;
  logic [SIZE_W-1:0]   amount_r, amount_nxt;
  logic [CNT_W-1:0]    limit_r, limit_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;

  // result staging
  logic [1:0]          res_status_r, res_status_nxt;
  logic [INDEX_W-1:0]  res_index_r, res_index_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [SIZE_W-1:0]   res_size_r, res_size_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [SIZE_W-1:0]   out_size_r, out_size_nxt;

  // table port
  logic                tbl_wr_en;
  logic [IDX_W-1:0]    tbl_wr_idx;
  entry_t              tbl_wr_data;
  logic [IDX_W-1:0]    tbl_rd_idx;
  entry_t              tbl_rd_data;

  logic                in_fire;
  logic                out_free;
  logic [CNT_W-1:0]    scan_next_cnt;
  logic                scan_hit;
  logic                rel_bad;

  fpfa_table #(
    .PARTITIONS (PARTITIONS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_idx  (tbl_wr_idx),
    .wr_data (tbl_wr_data),
    .rd_idx  (tbl_rd_idx),
    .rd_data (tbl_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // one-based index of the entry under the scan pointer
  assign scan_next_cnt = CNT_W'(scan_r) + CNT_W'(1);
  assign scan_hit      = (tbl_rd_data.size >= amount_r) && !tbl_rd_data.busy;
  assign rel_bad       = (in_release_index == '0) ||
                         (32'(in_release_index) > PARTITIONS);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    load_cnt_nxt   = load_cnt_r;
    run_end_nxt    = run_end_r;
    amount_nxt     = amount_r;
    limit_nxt      = limit_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_addr_nxt   = res_addr_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_addr_nxt   = out_addr_r;
    out_size_nxt   = out_size_r;
    tbl_wr_en      = 1'b0;
    tbl_wr_idx     = scan_r;
    tbl_wr_data    = tbl_rd_data;
    tbl_rd_idx     = scan_r;

    if (cfg_valid && cfg_ready) begin
      count_nxt = cfg_partition_count;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          amount_nxt     = in_amount;
          // failure default; overwritten on success, or with no-fit by an allocate
          res_status_nxt = STATUS_ERROR;
          res_index_nxt  = '0;
          res_addr_nxt   = '0;
          res_size_nxt   = '0;
          state_nxt      = ST_PUSH;
          unique case (in_req_type)
            REQ_LOAD: begin
              if (load_cnt_r < CNT_W'(PARTITIONS)) begin
                tbl_wr_en      = 1'b1;
                tbl_wr_idx     = load_cnt_r[IDX_W-1:0];
                tbl_wr_data    = '{size: in_amount, addr: run_end_r, busy: 1'b0};
                run_end_nxt    = run_end_r + ADDR_W'(in_amount);
                load_cnt_nxt   = load_cnt_r + CNT_W'(1);
                res_status_nxt = STATUS_OK;
                res_index_nxt  = INDEX_W'(load_cnt_r + CNT_W'(1));
                res_addr_nxt   = run_end_r;
                res_size_nxt   = in_amount;
              end
            end
            REQ_ALLOC: begin
              // scan limit is min(partition_count, PARTITIONS)
              if (32'(count_r) < PARTITIONS) begin
                limit_nxt = CNT_W'(count_r);
              end else begin
                limit_nxt = CNT_W'(PARTITIONS);
              end
              res_status_nxt = STATUS_NO_FIT;
              scan_nxt       = '0;
              tbl_rd_idx     = '0;
              if (limit_nxt != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            REQ_RELEASE: begin
              if (!rel_bad) begin
                scan_nxt   = IDX_W'(in_release_index - INDEX_W'(1));
                tbl_rd_idx = scan_nxt;
                state_nxt  = ST_REL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_hit) begin
          tbl_wr_en        = 1'b1;
          tbl_wr_data.busy = 1'b1;
          res_status_nxt   = STATUS_OK;
          res_index_nxt    = INDEX_W'(scan_next_cnt);
          res_addr_nxt     = tbl_rd_data.addr;
          res_size_nxt     = tbl_rd_data.size;
          state_nxt        = ST_PUSH;
        end else if (scan_next_cnt >= limit_r) begin
          state_nxt = ST_PUSH;
        end else begin
          scan_nxt   = scan_r + IDX_W'(1);
          tbl_rd_idx = scan_nxt;
        end
      end

      ST_REL: begin
        tbl_wr_en        = 1'b1;
        tbl_wr_data.busy = 1'b0;
        res_status_nxt   = STATUS_OK;
        res_index_nxt    = INDEX_W'(scan_next_cnt);
        res_addr_nxt     = tbl_rd_data.addr;
        res_size_nxt     = tbl_rd_data.size;
        state_nxt        = ST_PUSH;
      end

      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          out_addr_nxt   = res_addr_r;
          out_size_nxt   = res_size_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      load_cnt_r  <= '0;
      run_end_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      load_cnt_r  <= load_cnt_nxt;
      run_end_r   <= run_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
    amount_r     <= amount_nxt;
    limit_r      <= limit_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_addr_r   <= res_addr_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_addr_r   <= out_addr_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_part_index   = out_index_r;
  assign out_part_address = out_addr_r;
  assign out_part_size    = out_size_r;

endmodule
